[design/iia_pkg.sv]
// Shared constants and types for the integral image adaptive threshold block.
package iia_pkg;
   localparam int MaxWidth  = 512;
   localparam int MaxHeight = 512;
   localparam int XBits     = $clog2(MaxWidth);
   localparam int YBits     = $clog2(MaxHeight);
   localparam int AddrBits  = XBits + YBits;
   localparam int PixDepth  = MaxWidth * MaxHeight;
   localparam int SatBits   = 27;
   localparam int ColBits   = 17;

   localparam logic [1:0] REG_WIDTH   = 2'd0;
   localparam logic [1:0] REG_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_HALF    = 2'd2;
   localparam logic [1:0] REG_PERCENT = 2'd3;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_FETCH = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_LOAD = 9'b000000010,
      ST_F0   = 9'b000000100,
      ST_F1   = 9'b000001000,
      ST_F2   = 9'b000010000,
      ST_F3   = 9'b000100000,
      ST_F4   = 9'b001000000,
      ST_F5   = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;
endpackage

[design/iia_ram.sv]
// Generic single-port RAM with registered read.
module iia_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

[design/integral_image_adaptive_threshold.sv]
// A load passes through ST_LOAD; a fetch steps through ST_F0 to ST_F5 and ST_OUT, which
// registers rsp_valid and holds while a response waits on rsp_ready; a fetch before a
// full frame goes straight to ST_OUT. Requests are taken only in idle; a fetch is paced
// by the four corner reads via the integral memory's single port and the multiply chain.
// Reset is synchronous, active high; memories are not cleared and no clearing pass runs.
// Top level: load builds the summed-area table, fetch thresholds each pixel.
module integral_image_adaptive_threshold (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_out,
   output logic        rsp_last_of_frame,
   output logic        rsp_not_ready,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   iia_pkg::state_type state_ff, state_in;

   logic [9:0] width_ff, height_ff;
   logic [7:0] half_ff;
   logic [6:0] pct_ff;

   logic [iia_pkg::XBits-1:0] lx_ff, fx_ff, cx_ff, x1_ff, x2_ff;
   logic [iia_pkg::YBits-1:0] ly_ff, fy_ff, cy_ff, y1_ff, y2_ff;
   logic          loaded_ff, last_ff, nr_ff;
   logic [7:0]    pix_in_ff;
   logic [iia_pkg::SatBits-1:0] row_ff;
   logic [27:0]   acc_ff;
   logic [17:0]   area_ff;
   logic [25:0]   prod_ff;
   logic [33:0]   lhs_ff, rhs_ff;
   logic          rsp_valid_ff;
   logic [7:0]    out_pix_ff;
   logic          out_last_ff, out_nr_ff;

   logic [9:0]    weff, heff;
   logic [iia_pkg::XBits-1:0] wm1;
   logic [iia_pkg::YBits-1:0] hm1;
   logic          accept, cfg_wr, size_wr;
   logic [9:0]    xs, ys;
   logic [iia_pkg::XBits-1:0] x1c, x2c;
   logic [iia_pkg::YBits-1:0] y1c, y2c;
   logic [6:0]    pct_sat;

   logic                         col_we, sat_we, pix_we;
   logic [iia_pkg::XBits-1:0]    col_addr;
   logic [iia_pkg::AddrBits-1:0] sat_addr, pix_addr;
   logic [iia_pkg::ColBits-1:0]  col_rd, col_new;
   logic [iia_pkg::SatBits-1:0]  sat_rd, row_new;
   logic [7:0]                   pix_rd;

   assign weff = (width_ff == 10'd0) ? 10'd1 :
                 (width_ff > 10'(iia_pkg::MaxWidth)) ? 10'(iia_pkg::MaxWidth) : width_ff;
   assign heff = (height_ff == 10'd0) ? 10'd1 :
                 (height_ff > 10'(iia_pkg::MaxHeight)) ? 10'(iia_pkg::MaxHeight) : height_ff;
   assign wm1 = iia_pkg::XBits'(weff - 10'd1);
   assign hm1 = iia_pkg::YBits'(heff - 10'd1);
   assign pct_sat = (pct_ff > 7'd100) ? 7'd100 : pct_ff;

   assign req_ready = (state_ff == iia_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite;
   assign size_wr   = cfg_wr && (paddr[3:2] == iia_pkg::REG_WIDTH ||
                                 paddr[3:2] == iia_pkg::REG_HEIGHT);

   always_comb begin
      case (paddr[3:2])
         iia_pkg::REG_WIDTH:   prdata = {22'd0, width_ff};
         iia_pkg::REG_HEIGHT:  prdata = {22'd0, height_ff};
         iia_pkg::REG_HALF:    prdata = {24'd0, half_ff};
         iia_pkg::REG_PERCENT: prdata = {25'd0, pct_ff};
         default:              prdata = 32'd0;
      endcase
   end

   // clamped window around the next fetch position
   assign xs  = 10'(fx_ff) + 10'(half_ff);
   assign ys  = 10'(fy_ff) + 10'(half_ff);
   assign x1c = (10'(fx_ff) > 10'(half_ff)) ?
                iia_pkg::XBits'(10'(fx_ff) - 10'(half_ff)) : '0;
   assign y1c = (10'(fy_ff) > 10'(half_ff)) ?
                iia_pkg::YBits'(10'(fy_ff) - 10'(half_ff)) : '0;
   assign x2c = (xs > 10'(wm1)) ? wm1 : iia_pkg::XBits'(xs);
   assign y2c = (ys > 10'(hm1)) ? hm1 : iia_pkg::YBits'(ys);

   // load arithmetic: first row sees zeroed column sums
   assign col_new = ((ly_ff == '0) ? '0 : col_rd) + iia_pkg::ColBits'(pix_in_ff);
   assign row_new = ((lx_ff == '0) ? '0 : row_ff) + iia_pkg::SatBits'(col_new);

   assign col_we   = (state_ff == iia_pkg::ST_LOAD);
   assign col_addr = lx_ff;
   assign pix_we   = col_we;
   assign sat_we   = col_we;
   assign pix_addr = col_we ? {ly_ff, lx_ff} : {cy_ff, cx_ff};

   always_comb begin
      case (state_ff)
         iia_pkg::ST_F0: sat_addr = {y2_ff, x2_ff};
         iia_pkg::ST_F1: sat_addr = {y1_ff, x1_ff};
         iia_pkg::ST_F2: sat_addr = {y1_ff, x2_ff};
         iia_pkg::ST_F3: sat_addr = {y2_ff, x1_ff};
         default:        sat_addr = {ly_ff, lx_ff};
      endcase
   end

   iia_ram #(.Width(iia_pkg::ColBits), .Depth(iia_pkg::MaxWidth)) u_col (
      .clock(clock), .we(col_we), .addr(col_addr), .wdata(col_new), .rdata(col_rd));
   iia_ram #(.Width(iia_pkg::SatBits), .Depth(iia_pkg::PixDepth)) u_sat (
      .clock(clock), .we(sat_we), .addr(sat_addr), .wdata(row_new), .rdata(sat_rd));
   iia_ram #(.Width(8), .Depth(iia_pkg::PixDepth)) u_pix (
      .clock(clock), .we(pix_we), .addr(pix_addr), .wdata(pix_in_ff), .rdata(pix_rd));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iia_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_action == iia_pkg::ACT_LOAD) state_in = iia_pkg::ST_LOAD;
               else if (loaded_ff) state_in = iia_pkg::ST_F0;
               else state_in = iia_pkg::ST_OUT;
            end
         end
         iia_pkg::ST_LOAD: state_in = iia_pkg::ST_IDLE;
         iia_pkg::ST_F0:   state_in = iia_pkg::ST_F1;
         iia_pkg::ST_F1:   state_in = iia_pkg::ST_F2;
         iia_pkg::ST_F2:   state_in = iia_pkg::ST_F3;
         iia_pkg::ST_F3:   state_in = iia_pkg::ST_F4;
         iia_pkg::ST_F4:   state_in = iia_pkg::ST_F5;
         iia_pkg::ST_F5:   state_in = iia_pkg::ST_OUT;
         iia_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = iia_pkg::ST_IDLE;
         end
         default: state_in = iia_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iia_pkg::ST_IDLE;
         width_ff     <= 10'd512;
         height_ff    <= 10'd512;
         half_ff      <= 8'd25;
         pct_ff       <= 7'd25;
         lx_ff        <= '0;
         ly_ff        <= '0;
         fx_ff        <= '0;
         fy_ff        <= '0;
         loaded_ff    <= 1'b0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            case (paddr[3:2])
               iia_pkg::REG_WIDTH:   width_ff  <= pwdata[9:0];
               iia_pkg::REG_HEIGHT:  height_ff <= pwdata[9:0];
               iia_pkg::REG_HALF:    half_ff   <= pwdata[7:0];
               iia_pkg::REG_PERCENT: pct_ff    <= pwdata[6:0];
               default: ;
            endcase
         end
         if (size_wr) begin
            lx_ff     <= '0;
            ly_ff     <= '0;
            fx_ff     <= '0;
            fy_ff     <= '0;
            loaded_ff <= 1'b0;
         end else if (state_ff == iia_pkg::ST_LOAD) begin
            row_ff <= row_new;
            if (lx_ff == wm1 && ly_ff == hm1) begin
               lx_ff     <= '0;
               ly_ff     <= '0;
               fx_ff     <= '0;
               fy_ff     <= '0;
               loaded_ff <= 1'b1;
            end else begin
               // a new frame starts: drop the old one
               if (lx_ff == '0 && ly_ff == '0) loaded_ff <= 1'b0;
               if (lx_ff == wm1) begin
                  lx_ff <= '0;
                  ly_ff <= ly_ff + iia_pkg::YBits'(1);
               end else begin
                  lx_ff <= lx_ff + iia_pkg::XBits'(1);
               end
            end
         end else if (accept && req_action == iia_pkg::ACT_FETCH && loaded_ff) begin
            if (fx_ff == wm1) begin
               fx_ff <= '0;
               fy_ff <= (fy_ff == hm1) ? '0 : fy_ff + iia_pkg::YBits'(1);
            end else begin
               fx_ff <= fx_ff + iia_pkg::XBits'(1);
            end
         end
         if (state_ff == iia_pkg::ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_in_ff <= req_pixel_in;
         cx_ff     <= fx_ff;
         cy_ff     <= fy_ff;
         x1_ff     <= x1c;
         x2_ff     <= x2c;
         y1_ff     <= y1c;
         y2_ff     <= y2c;
         last_ff   <= (fx_ff == wm1) && (fy_ff == hm1);
         nr_ff     <= !loaded_ff;
      end
      case (state_ff)
         iia_pkg::ST_F0: area_ff <= 18'((x2_ff - x1_ff) * (y2_ff - y1_ff));
         iia_pkg::ST_F1: begin
            acc_ff  <= 28'(sat_rd);
            prod_ff <= 26'(pix_rd * area_ff);
         end
         iia_pkg::ST_F2: begin
            acc_ff <= acc_ff + 28'(sat_rd);
            lhs_ff <= 34'(prod_ff) * 34'd100;
         end
         iia_pkg::ST_F3: acc_ff <= acc_ff - 28'(sat_rd);
         iia_pkg::ST_F4: acc_ff <= acc_ff - 28'(sat_rd);
         iia_pkg::ST_F5: rhs_ff <= 34'(acc_ff[26:0]) * 34'(7'd100 - pct_sat);
         iia_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_pix_ff  <= (nr_ff || lhs_ff <= rhs_ff) ? 8'd0 : 8'd255;
               out_last_ff <= !nr_ff && last_ff;
               out_nr_ff   <= nr_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_out     = out_pix_ff;
   assign rsp_last_of_frame = out_last_ff;
   assign rsp_not_ready     = out_nr_ff;
endmodule
